// ===== rtl/pct_pkg.sv =====
package pct_pkg;

  // Field widths of one request and one result.
  localparam int ADDR_W   = 48;
  localparam int STR_W    = 8;
  localparam int TIME_W   = 32;
  localparam int SETTLE_W = 16;
  localparam int ENTRY_W  = ADDR_W + STR_W;

  // Reset value of the settle time register.
  localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd5000;

  // Command codes.
  localparam logic [2:0] CMD_FOUND   = 3'd0;
  localparam logic [2:0] CMD_REJECT  = 3'd1;
  localparam logic [2:0] CMD_ATTEMPT = 3'd2;
  localparam logic [2:0] CMD_READY   = 3'd3;
  localparam logic [2:0] CMD_STOP    = 3'd4;

  // Result kinds.
  localparam logic KIND_BEACON  = 1'b0;
  localparam logic KIND_CONNECT = 1'b1;

  // Beacon destination.
  localparam logic [ADDR_W-1:0] BCAST_ADDR = '1;

  // Sequencer states.
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_DRAIN  = 6'b000100,
    S_DECIDE = 6'b001000,
    S_SH_RD  = 6'b010000,
    S_SH_WR  = 6'b100000
  } state_t;

endpackage

// ===== rtl/pct_ram.sv =====
module pct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/parent_candidate_table.sv =====
// Parent candidate table.
// A request is taken when start is high and busy is low. The command fields
// (in_cmd, in_peer_address, in_strength, in_now_ticks) are sampled at that
// edge. Results appear on the out_ ports for one cycle, marked by out_valid;
// the receiver must take them, it cannot hold them off.
// Entries live in one RAM with a registered read port. A found or reject
// scans the entries one per cycle. A reject then closes the gap by reading
// each moved entry and writing it back one place down. A found into an
// empty table, ready, stop and unused codes are handled without leaving
// idle. An attempt, while enabled, puts its beacon out the cycle after the
// request; when a connect request follows, it appears after a scan for the
// strongest entry. The scan and the compaction never touch one entry with
// overlapping read and write, so no forwarding is needed.
// settle_ticks is written through cfg_we and cfg_wdata; the user must do
// so only while idle; it is not enforced. Reset empties the table, clears
// the enable flag and the time stamp and sets settle_ticks to 5000. No RAM
// clearing pass is needed since only entries below the count are read.
module parent_candidate_table #(
  parameter int TABLE_DEPTH = 5
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [2:0]                     in_cmd,
  input  logic [pct_pkg::ADDR_W-1:0]     in_peer_address,
  input  logic [pct_pkg::STR_W-1:0]      in_strength,
  input  logic [pct_pkg::TIME_W-1:0]     in_now_ticks,
  output logic                           out_valid,
  output logic                           out_request_kind,
  output logic [pct_pkg::ADDR_W-1:0]     out_target_address,
  output logic [pct_pkg::STR_W-1:0]      out_target_strength,
  output logic                           out_last,
  input  logic                           cfg_we,
  input  logic [pct_pkg::SETTLE_W-1:0]   cfg_wdata
);

  import pct_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

  state_t              state_r, state_nxt;
  logic [2:0]          cmd_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [STR_W-1:0]    str_r;
  logic [CW-1:0]       count_r, count_nxt;
  logic [TIME_W-1:0]   first_r, first_nxt;
  logic                enabled_r, enabled_nxt;
  logic [SETTLE_W-1:0] settle_r;
  logic [IW-1:0]       idx_r, idx_nxt;

  logic                rvld_r;
  logic [IW-1:0]       rtag_r;
  logic                hit_vld_r;
  logic [IW-1:0]       hit_idx_r;
  logic [ADDR_W-1:0]   best_addr_r;
  logic [STR_W-1:0]    best_str_r;
  logic [IW-1:0]       worst_idx_r;
  logic [STR_W-1:0]    worst_str_r;

  logic                out_valid_r, out_valid_nxt;
  logic                out_kind_r, out_kind_nxt;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  logic [STR_W-1:0]    out_str_r, out_str_nxt;
  logic                out_last_r, out_last_nxt;

  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [IW-1:0]       ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic [ADDR_W-1:0]   rd_addr;
  logic [STR_W-1:0]    rd_str;

  logic                accept;
  logic [TIME_W-1:0]   elapsed;
  logic                connect;
  logic [CW:0]         idx_ext_inc;
  logic [CW:0]         hit_ext_inc;
  logic [CW:0]         count_ext;
  logic [IW-1:0]       idx_inc;

  pct_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign rd_addr   = ram_rdata[ENTRY_W-1:STR_W];
  assign rd_str    = ram_rdata[STR_W-1:0];

  // Wait test with wrapping time.
  assign elapsed   = in_now_ticks - first_r;
  assign connect   = (count_r != '0) && (elapsed >= {{(TIME_W-SETTLE_W){1'b0}}, settle_r});

  // Index arithmetic, one bit wider than the count so that no sum wraps.
  assign idx_inc     = idx_r + IW'(1);
  assign idx_ext_inc = {{(CW+1-IW){1'b0}}, idx_r} + (CW+1)'(1);
  assign hit_ext_inc = {{(CW+1-IW){1'b0}}, hit_idx_r} + (CW+1)'(1);
  assign count_ext   = {1'b0, count_r};

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    first_nxt     = first_r;
    enabled_nxt   = enabled_r;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_addr_nxt  = out_addr_r;
    out_str_nxt   = out_str_r;
    out_last_nxt  = out_last_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = {addr_r, str_r};
    ram_raddr     = idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            CMD_FOUND: begin
              if (count_r == '0) begin
                // First entry of an empty table: stamp and append at once.
                first_nxt = in_now_ticks;
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = {in_peer_address, in_strength};
                count_nxt = CW'(1);
              end else begin
                idx_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
            CMD_REJECT: begin
              if (count_r != '0) begin
                idx_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
            CMD_ATTEMPT: begin
              if (enabled_r) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_BEACON;
                out_addr_nxt  = BCAST_ADDR;
                out_str_nxt   = '0;
                out_last_nxt  = !connect;
                if (connect) begin
                  idx_nxt   = '0;
                  state_nxt = S_SCAN;
                end
              end
            end
            CMD_READY: begin
              enabled_nxt = 1'b1;
            end
            CMD_STOP: begin
              count_nxt   = '0;
              enabled_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      // Read every valid entry, one per cycle.
      S_SCAN: begin
        ram_raddr = idx_r;
        if (idx_ext_inc == count_ext) begin
          state_nxt = S_DRAIN;
        end else begin
          idx_nxt = idx_inc;
        end
      end

      // The last read data is folded into the scan results here.
      S_DRAIN: begin
        state_nxt = S_DECIDE;
      end

      S_DECIDE: begin
        state_nxt = S_IDLE;
        case (cmd_r)
          CMD_FOUND: begin
            ram_we = 1'b1;
            if (hit_vld_r) begin
              ram_waddr = hit_idx_r;
            end else if (count_r == FULL_COUNT) begin
              ram_waddr = worst_idx_r;
            end else begin
              ram_waddr = count_r[IW-1:0];
              count_nxt = count_r + CW'(1);
            end
          end
          CMD_REJECT: begin
            if (hit_vld_r) begin
              count_nxt = count_r - CW'(1);
              idx_nxt   = hit_idx_r;
              if (hit_ext_inc < count_ext) begin
                state_nxt = S_SH_RD;
              end
            end
          end
          CMD_ATTEMPT: begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_CONNECT;
            out_addr_nxt  = best_addr_r;
            out_str_nxt   = best_str_r;
            out_last_nxt  = 1'b1;
          end
          default: begin
          end
        endcase
      end

      // Compaction: read the next entry.
      S_SH_RD: begin
        ram_raddr = idx_inc;
        state_nxt = S_SH_WR;
      end

      // Compaction: write it one place down. count_r already holds the new count.
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = ram_rdata;
        idx_nxt   = idx_inc;
        if (idx_ext_inc < count_ext) begin
          state_nxt = S_SH_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      first_r     <= '0;
      enabled_r   <= 1'b0;
      settle_r    <= SETTLE_RESET;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      rvld_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      first_r     <= first_nxt;
      enabled_r   <= enabled_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      rvld_r      <= (state_r == S_SCAN);
      if (cfg_we) begin
        settle_r <= cfg_wdata;
      end
    end
  end

  // Request fields and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_cmd;
      addr_r <= in_peer_address;
      str_r  <= in_strength;
    end
    rtag_r     <= idx_r;
    out_kind_r <= out_kind_nxt;
    out_addr_r <= out_addr_nxt;
    out_str_r  <= out_str_nxt;
    out_last_r <= out_last_nxt;
  end

  // Scan results: first match, first strongest and first weakest entry.
  always_ff @(posedge clk) begin
    if (rvld_r) begin
      if (rtag_r == '0) begin
        hit_vld_r   <= (rd_addr == addr_r);
        hit_idx_r   <= '0;
        best_addr_r <= rd_addr;
        best_str_r  <= rd_str;
        worst_idx_r <= '0;
        worst_str_r <= rd_str;
      end else begin
        if (!hit_vld_r && (rd_addr == addr_r)) begin
          hit_vld_r <= 1'b1;
          hit_idx_r <= rtag_r;
        end
        if (rd_str > best_str_r) begin
          best_addr_r <= rd_addr;
          best_str_r  <= rd_str;
        end
        if (rd_str < worst_str_r) begin
          worst_idx_r <= rtag_r;
          worst_str_r <= rd_str;
        end
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_request_kind    = out_kind_r;
  assign out_target_address  = out_addr_r;
  assign out_target_strength = out_str_r;
  assign out_last            = out_last_r;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import pct_pkg::*;

  localparam int DEPTH     = 5;
  localparam int MAX_SHOWN = 10;
  localparam int PHASES    = 6;
  localparam int PER_PHASE = 290;
  localparam int POOL_SIZE = 8;

  // Command codes the block ignores.
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [ADDR_W-1:0] peer;
    logic [STR_W-1:0]  strength;
    logic [TIME_W-1:0] now;
  } pct_cmd_t;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] addr;
    logic [STR_W-1:0]  strength;
    logic              is_last;
  } link_request_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [2:0]          in_cmd = CMD_FOUND;
  logic [ADDR_W-1:0]   in_peer_address = '0;
  logic [STR_W-1:0]    in_strength = '0;
  logic [TIME_W-1:0]   in_now_ticks = '0;
  logic                out_valid;
  logic                out_request_kind;
  logic [ADDR_W-1:0]   out_target_address;
  logic [STR_W-1:0]    out_target_strength;
  logic                out_last;
  logic                cfg_we = 1'b0;
  logic [SETTLE_W-1:0] cfg_wdata = '0;

  parent_candidate_table #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_cmd             (in_cmd),
    .in_peer_address    (in_peer_address),
    .in_strength        (in_strength),
    .in_now_ticks       (in_now_ticks),
    .out_valid          (out_valid),
    .out_request_kind   (out_request_kind),
    .out_target_address (out_target_address),
    .out_target_strength(out_target_strength),
    .out_last           (out_last),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  // Predicted state of the candidate table.
  logic [ADDR_W-1:0]   tbl_addr [DEPTH];
  logic [STR_W-1:0]    tbl_str [DEPTH];
  int                  tbl_count = 0;
  logic [TIME_W-1:0]   stamp_ticks = '0;
  logic                link_enabled = 1'b0;
  logic [SETTLE_W-1:0] settle_model = SETTLE_RESET;
  link_request_t       results_due[$];

  // Stimulus bookkeeping.
  pct_cmd_t            pending[$];
  pct_cmd_t            next_req;
  logic                req_taken = 1'b0;
  logic                no_gaps = 1'b0;
  int                  items_issued = 0;
  int                  items_taken = 0;
  logic [ADDR_W-1:0]   addr_pool [POOL_SIZE];
  logic [TIME_W-1:0]   sim_ticks = '0;
  int                  step_max = 16;

  // Checking and coverage counters.
  link_request_t       seen_req;
  link_request_t       due_req;
  int                  errors = 0;
  int                  n_beacon = 0;
  int                  n_connect = 0;
  int                  n_replace = 0;
  int                  n_compact = 0;
  int                  n_settings = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  // Work out the results of one accepted request and update the table.
  function automatic void predict_results(input pct_cmd_t c);
    int                hit;
    int                slot;
    int                i;
    logic              connect;
    logic [TIME_W-1:0] waited;
    link_request_t     due;
    hit = -1;
    for (i = 0; i < tbl_count; i++) begin
      if (hit < 0 && tbl_addr[i] == c.peer) begin
        hit = i;
      end
    end
    case (c.cmd)
      CMD_FOUND: begin
        // The first find into an empty table stamps the time.
        if (tbl_count == 0) begin
          stamp_ticks = c.now;
        end
        if (hit >= 0) begin
          tbl_str[hit] = c.strength;
        end else if (tbl_count == DEPTH) begin
          // A full table loses its first weakest entry.
          slot = 0;
          for (i = 1; i < DEPTH; i++) begin
            if (tbl_str[i] < tbl_str[slot]) begin
              slot = i;
            end
          end
          tbl_addr[slot] = c.peer;
          tbl_str[slot] = c.strength;
          n_replace++;
        end else begin
          tbl_addr[tbl_count] = c.peer;
          tbl_str[tbl_count] = c.strength;
          tbl_count++;
        end
      end
      CMD_REJECT: begin
        // Remove the entry and close the gap, keeping the order.
        if (hit >= 0) begin
          for (i = hit; i + 1 < tbl_count; i++) begin
            tbl_addr[i] = tbl_addr[i + 1];
            tbl_str[i] = tbl_str[i + 1];
          end
          tbl_count--;
          n_compact++;
        end
      end
      CMD_ATTEMPT: begin
        if (link_enabled) begin
          waited = c.now - stamp_ticks;
          connect = (tbl_count > 0) && (waited >= TIME_W'(settle_model));
          due = '{kind: KIND_BEACON, addr: BCAST_ADDR, strength: '0, is_last: !connect};
          results_due.insert(results_due.size(), due);
          if (connect) begin
            // The first strongest entry wins.
            slot = 0;
            for (i = 1; i < tbl_count; i++) begin
              if (tbl_str[i] > tbl_str[slot]) begin
                slot = i;
              end
            end
            due = '{kind: KIND_CONNECT, addr: tbl_addr[slot],
                    strength: tbl_str[slot], is_last: 1'b1};
            results_due.insert(results_due.size(), due);
          end
        end
      end
      CMD_READY: begin
        link_enabled = 1'b1;
      end
      CMD_STOP: begin
        tbl_count = 0;
        link_enabled = 1'b0;
      end
      default: begin
      end
    endcase
  endfunction

  // Driver: present the next request at the falling edge, hold it until taken.
  always @(negedge clk) begin
    if (!start || req_taken) begin
      if (rst_n && pending.size() > 0 && (no_gaps || $urandom_range(0, 99) >= 9)) begin
        next_req = pending.pop_front();
        start <= 1'b1;
        in_cmd <= next_req.cmd;
        in_peer_address <= next_req.peer;
        in_strength <= next_req.strength;
        in_now_ticks <= next_req.now;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check results, track the register and predict each accepted request.
  always @(posedge clk) begin
    if (!rst_n) begin
      req_taken = 1'b0;
    end else begin
      if (out_valid) begin
        seen_req = '{kind: out_request_kind, addr: out_target_address,
                     strength: out_target_strength, is_last: out_last};
        if (results_due.size() == 0) begin
          errors++;
          if (errors <= MAX_SHOWN) begin
            $display("Unexpected result: kind %0d addr %h strength %0d last %0d",
                     seen_req.kind, seen_req.addr, seen_req.strength, seen_req.is_last);
          end
        end else begin
          due_req = results_due.pop_front();
          if (seen_req.kind !== due_req.kind || seen_req.addr !== due_req.addr ||
              seen_req.strength !== due_req.strength ||
              seen_req.is_last !== due_req.is_last) begin
            errors++;
            if (errors <= MAX_SHOWN) begin
              $display("Mismatch: expected kind %0d addr %h strength %0d last %0d",
                       due_req.kind, due_req.addr, due_req.strength, due_req.is_last);
              $display("          got      kind %0d addr %h strength %0d last %0d",
                       seen_req.kind, seen_req.addr, seen_req.strength, seen_req.is_last);
            end
          end else if (seen_req.kind == KIND_CONNECT) begin
            n_connect++;
          end else begin
            n_beacon++;
          end
        end
      end
      if (cfg_we) begin
        settle_model = cfg_wdata;
      end
      req_taken = start && !busy;
      if (req_taken) begin
        predict_results('{cmd: in_cmd, peer: in_peer_address,
                          strength: in_strength, now: in_now_ticks});
        items_taken++;
      end
    end
  end

  task automatic add_req(input logic [2:0] c, input logic [ADDR_W-1:0] a,
                         input logic [STR_W-1:0] s, input logic [TIME_W-1:0] t);
    pct_cmd_t item;
    item = '{cmd: c, peer: a, strength: s, now: t};
    pending.insert(pending.size(), item);
    items_issued++;
  endtask

  // Mostly table traffic over a small address pool, with some noise.
  task automatic queue_random();
    int                r;
    logic [ADDR_W-1:0] a;
    logic [STR_W-1:0]  s;
    r = $urandom_range(0, 99);
    a = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    // Small strengths often, so that ties come up.
    s = ($urandom_range(0, 1) != 0) ? STR_W'($urandom_range(0, 3)) : STR_W'($urandom);
    sim_ticks += TIME_W'($urandom_range(0, step_max));
    if ($urandom_range(0, 59) == 0) begin
      sim_ticks = $urandom;
    end
    if (r < 38) begin
      add_req(CMD_FOUND, a, s, sim_ticks);
    end else if (r < 52) begin
      add_req(CMD_REJECT, a, STR_W'($urandom), $urandom);
    end else if (r < 77) begin
      add_req(CMD_ATTEMPT, ADDR_W'({$urandom, $urandom}), STR_W'($urandom), sim_ticks);
    end else if (r < 86) begin
      add_req(CMD_READY, ADDR_W'({$urandom, $urandom}), STR_W'($urandom), $urandom);
    end else if (r < 90) begin
      add_req(CMD_STOP, ADDR_W'({$urandom, $urandom}), STR_W'($urandom), $urandom);
    end else if (r < 93) begin
      add_req(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)),
              ADDR_W'({$urandom, $urandom}), STR_W'($urandom), $urandom);
    end else begin
      add_req(3'($urandom_range(0, 7)), ADDR_W'({$urandom, $urandom}),
              STR_W'($urandom), $urandom);
    end
  endtask

  // Edge cases: stamp across the wrap, ties, full table, compaction, stop.
  task automatic queue_directed();
    add_req(CMD_ATTEMPT, '0, '0, 32'd0);
    add_req(CMD_READY, '0, '0, '0);
    add_req(CMD_ATTEMPT, '0, '0, 32'd100);
    add_req(CMD_FOUND, 48'h0, 8'd0, 32'hFFFF_F000);
    add_req(CMD_ATTEMPT, '0, '0, 32'h0000_0387);
    add_req(CMD_ATTEMPT, '0, '0, 32'h0000_0388);
    add_req(CMD_FOUND, 48'hFFFF_FFFF_FFFF, 8'd255, 32'd0);
    add_req(CMD_FOUND, 48'h5555_5555_5555, 8'd255, 32'd0);
    add_req(CMD_FOUND, 48'hAAAA_AAAA_AAAA, 8'd7, 32'd0);
    add_req(CMD_FOUND, 48'h0, 8'd200, 32'd0);
    add_req(CMD_FOUND, 48'h1234_5678_9ABC, 8'd7, 32'd0);
    add_req(CMD_FOUND, 48'h0F0F_0F0F_0F0F, 8'd9, 32'd0);
    add_req(CMD_ATTEMPT, '0, '0, 32'h0001_0000);
    add_req(CMD_REJECT, 48'hDEAD_BEEF_0001, '0, '0);
    add_req(CMD_REJECT, 48'hFFFF_FFFF_FFFF, '0, '0);
    add_req(CMD_ATTEMPT, '0, '0, 32'h0001_0000);
    add_req(CMD_UNUSED_LO, 48'hFFFF_FFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
    add_req(CMD_UNUSED_LO + 3'd1, ADDR_W'({$urandom, $urandom}), STR_W'($urandom), $urandom);
    add_req(CMD_UNUSED_HI, ADDR_W'({$urandom, $urandom}), STR_W'($urandom), $urandom);
    add_req(CMD_STOP, '0, '0, '0);
    add_req(CMD_ATTEMPT, '0, '0, 32'h0100_0000);
    add_req(CMD_READY, '0, '0, '0);
    add_req(CMD_FOUND, 48'h8000_0000_0001, 8'd128, 32'd500);
    add_req(CMD_ATTEMPT, '0, '0, 32'd499);
    add_req(CMD_REJECT, 48'h8000_0000_0001, '0, '0);
    add_req(CMD_ATTEMPT, '0, '0, 32'd600);
  endtask

  // Wait until every request is taken and answered, then let the block settle.
  task automatic drain_and_settle();
    do begin
      @(negedge clk);
    end while (items_taken != items_issued || results_due.size() != 0);
    repeat (30) @(negedge clk);
    while (busy) begin
      @(negedge clk);
    end
  endtask

  task automatic write_settle(input logic [SETTLE_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Sequencer: reset, directed part, then random phases at several settle times.
  initial begin
    logic [SETTLE_W-1:0] settle_plan [PHASES];
    int                  p;
    int                  k;
    settle_plan = '{16'd0, 16'hFFFF, 16'd1, SETTLE_W'($urandom), 16'd5000,
                    SETTLE_W'($urandom_range(2, 300))};
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    queue_directed();
    drain_and_settle();
    for (p = 0; p < PHASES; p++) begin
      write_settle(settle_plan[p]);
      for (k = 0; k < POOL_SIZE; k++) begin
        addr_pool[k] = ADDR_W'({$urandom, $urandom});
      end
      step_max = int'(settle_plan[p]) / 3 + 16;
      sim_ticks = $urandom;
      // One phase runs back to back with no gaps at all.
      no_gaps = (p == 2);
      for (k = 0; k < PER_PHASE; k++) begin
        queue_random();
      end
      drain_and_settle();
      no_gaps = 1'b0;
    end
    errors += results_due.size();
    $display("Ran %0d requests at %0d settle times: %0d beacons, %0d connect results.",
             items_issued, n_settings + 1, n_beacon, n_connect);
    $display("The table saw %0d replacements when full and %0d removals.",
             n_replace, n_compact);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Guard against a hung block.
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
